// File: src/i2cseq_pkg.sv
// -----------------------------------------------------------------------------
// i2cseq_pkg
// Shared types and constants for the i2c master transfer sequencer: phase and
// status codes, the result record and the address byte mask.
// -----------------------------------------------------------------------------
package i2cseq_pkg;

   // sequencer phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TX   = 2'd1,
      PH_RX   = 2'd2
   } phase_type;

   // status reported with every result
   typedef enum logic [2:0] {
      ST_BUSY     = 3'd0,
      ST_DONE     = 3'd1,
      ST_NACK     = 3'd2,
      ST_REJECT   = 3'd3,
      ST_SPURIOUS = 3'd4
   } status_type;

   // address byte keeps the upper seven bits, the low bit is the direction
   localparam logic [7:0] ADDR_MASK = 8'hfe;

   localparam int COUNT_W = 16;

   // one result item
   typedef struct packed {
      logic               send_valid;
      logic [7:0]         send_byte;
      logic               recv_valid;
      logic [7:0]         recv_byte;
      logic               turn_receive;
      logic               nack_next;
      logic               stop;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

// File: src/i2c_master_transfer_sequencer_top.sv
// -----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top
// Sequences multi-byte i2c master transfers, one start or byte-complete event
// per item, with one result item per input item.
//
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  req_tdata, req_tuser (mode)
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser (status), rsp_tlast (stop)
// csr      in         csr_valid/csr_ready    csr_data (own address)
//
// One item per cycle while the result is not stalled: the result is registered on
// the edge that takes the transfer in, and the sequencer state updates on the same edge.
// A new item is taken while the result register is empty or being drained.
// A stalled result holds req_tready low; csr writes are always taken.
// Reset clears the phase, counters, own address and the result valid.
// -----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top #(
   parameter int LEN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] is_read, [8:1] slave_addr, [24:9] length, [25] nak,
   // [33:26] rx_byte, [41:34] tx_byte, [47:42] zero
   input  logic [47:0] req_tdata,
   // [0] mode
   input  logic        req_tuser,
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] send_valid, [8:1] send_byte, [9] recv_valid, [17:10] recv_byte,
   // [18] turn_receive, [19] nack_next, [35:20] count, [39:36] zero
   output logic [39:0] rsp_tdata,
   // [2:0] status
   output logic [2:0]  rsp_tuser,
   // stop
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic                   req_take;
   logic [7:0]             own_addr_ff;
   i2cseq_pkg::phase_type  phase_ff;
   i2cseq_pkg::phase_type  phase_in;
   logic                   reading_ff;
   logic                   reading_in;
   logic [LEN_BITS-1:0]    done_ff;
   logic [LEN_BITS-1:0]    done_in;
   logic [LEN_BITS-1:0]    total_ff;
   logic [LEN_BITS-1:0]    total_in;
   i2cseq_pkg::result_type result_in;
   i2cseq_pkg::result_type result_ff;
   logic                   rsp_valid_ff;

   // result register frees up when empty or drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // next state and result for the item on the request channel
   i2cseq_step #(
      .LEN_BITS (LEN_BITS)
   ) u_step (
      .mode        (req_tuser),
      .is_read     (req_tdata[0]),
      .slave_addr  (req_tdata[8:1]),
      .length      (req_tdata[24:9]),
      .nak         (req_tdata[25]),
      .rx_byte     (req_tdata[33:26]),
      .tx_byte     (req_tdata[41:34]),
      .own_address (own_addr_ff),
      .phase       (phase_ff),
      .reading     (reading_ff),
      .done_bytes  (done_ff),
      .total_bytes (total_ff),
      .phase_in    (phase_in),
      .reading_in  (reading_in),
      .done_in     (done_in),
      .total_in    (total_in),
      .result      (result_in)
   );

   // own address register
   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         own_addr_ff <= csr_data;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= i2cseq_pkg::PH_IDLE;
         reading_ff <= 1'b0;
         done_ff    <= '0;
         total_ff   <= '0;
      end else if (req_take) begin
         phase_ff   <= phase_in;
         reading_ff <= reading_in;
         done_ff    <= done_in;
         total_ff   <= total_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, result_ff.count, result_ff.nack_next, result_ff.turn_receive,
                        result_ff.recv_byte, result_ff.recv_valid,
                        result_ff.send_byte, result_ff.send_valid};
   assign rsp_tuser  = result_ff.status;
   assign rsp_tlast  = result_ff.stop;

   // a stalled result blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while result stalled");

   // every transfer in gives a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_tvalid)
      else $error("result missing after request transfer");

   // receive phase only within a read
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cseq_pkg::PH_RX) |-> reading_ff)
      else $error("receive phase without read transfer");

   // a stop ends with complete or slave nack
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tuser == i2cseq_pkg::ST_DONE || rsp_tuser == i2cseq_pkg::ST_NACK))
      else $error("stop with unexpected status");

endmodule

// File: src/i2cseq_step.sv
// -----------------------------------------------------------------------------
// i2cseq_step
// Next-state and result logic for one item: start of a transfer or one
// byte-complete event, evaluated against the current sequencer state.
// -----------------------------------------------------------------------------
module i2cseq_step #(
   parameter int LEN_BITS = 16
) (
   input  logic                  mode,
   input  logic                  is_read,
   input  logic [7:0]            slave_addr,
   input  logic [15:0]           length,
   input  logic                  nak,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            tx_byte,
   input  logic [7:0]            own_address,
   input  i2cseq_pkg::phase_type phase,
   input  logic                  reading,
   input  logic [LEN_BITS-1:0]   done_bytes,
   input  logic [LEN_BITS-1:0]   total_bytes,
   output i2cseq_pkg::phase_type phase_in,
   output logic                  reading_in,
   output logic [LEN_BITS-1:0]   done_in,
   output logic [LEN_BITS-1:0]   total_in,
   output i2cseq_pkg::result_type result
);

   localparam int WIDE = LEN_BITS + 1;

   logic [LEN_BITS-1:0] done_inc;
   logic [LEN_BITS:0]   done_plus2;

   // increment wraps at the counter width, the look-ahead compare does not
   assign done_inc   = done_bytes + LEN_BITS'(1);
   assign done_plus2 = {1'b0, done_bytes} + WIDE'(2);

   always_comb begin
      phase_in            = phase;
      reading_in          = reading;
      done_in             = done_bytes;
      total_in            = total_bytes;
      result.send_valid   = 1'b0;
      result.send_byte    = 8'd0;
      result.recv_valid   = 1'b0;
      result.recv_byte    = 8'd0;
      result.turn_receive = 1'b0;
      result.nack_next    = 1'b0;
      result.stop         = 1'b0;
      result.status       = i2cseq_pkg::ST_BUSY;
      result.count        = 16'd0;

      if (!mode) begin
         // start: reject a read of our own address, else send address byte
         if (is_read && (slave_addr == own_address)) begin
            result.status = i2cseq_pkg::ST_REJECT;
         end else begin
            result.send_valid = 1'b1;
            result.send_byte  = (slave_addr & i2cseq_pkg::ADDR_MASK) | {7'd0, is_read};
            phase_in          = i2cseq_pkg::PH_TX;
            reading_in        = is_read;
            done_in           = '0;
            total_in          = LEN_BITS'(length);
         end
      end else begin
         case (phase)
            // address phase or transmit data
            i2cseq_pkg::PH_TX: begin
               if (nak) begin
                  result.stop   = 1'b1;
                  result.status = i2cseq_pkg::ST_NACK;
                  phase_in      = i2cseq_pkg::PH_IDLE;
               end else if (done_bytes >= total_bytes) begin
                  result.stop   = 1'b1;
                  result.status = i2cseq_pkg::ST_DONE;
                  phase_in      = i2cseq_pkg::PH_IDLE;
               end else if (reading) begin
                  result.turn_receive = 1'b1;
                  result.nack_next    = (total_bytes == LEN_BITS'(1));
                  done_in             = '0;
                  phase_in            = i2cseq_pkg::PH_RX;
               end else begin
                  result.send_valid = 1'b1;
                  result.send_byte  = tx_byte;
                  done_in           = done_inc;
               end
            end
            // receive data
            i2cseq_pkg::PH_RX: begin
               if (done_bytes < total_bytes) begin
                  result.nack_next  = (done_plus2 == {1'b0, total_bytes});
                  result.recv_valid = 1'b1;
                  result.recv_byte  = rx_byte;
                  done_in           = done_inc;
                  if (done_inc == total_bytes) begin
                     result.stop   = 1'b1;
                     result.status = i2cseq_pkg::ST_DONE;
                     phase_in      = i2cseq_pkg::PH_IDLE;
                  end
               end else begin
                  result.status = i2cseq_pkg::ST_SPURIOUS;
                  phase_in      = i2cseq_pkg::PH_IDLE;
               end
            end
            // event with no transfer open
            default: begin
               result.status = i2cseq_pkg::ST_SPURIOUS;
               phase_in      = i2cseq_pkg::PH_IDLE;
            end
         endcase
         result.count = 16'(done_in);
      end
   end

endmodule
